// File: sv/pdd_pkg.sv
// Shared types, constants and a helper function for the path delta decoder.
package pdd_pkg;

    // Default internal coordinate width; output coordinate ports are always 64 bits wide.
    localparam int COORD_WIDTH_DEF = 64;
    localparam int OUT_WIDTH       = 64;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // Path command codes.
    typedef enum logic [1:0] {
        OP_END   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_LINE  = 2'd2,
        OP_CLOSE = 2'd3
    } op_e_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ZOOM        = 3'd0,
        CFG_TILE_X      = 3'd1,
        CFG_TILE_Y      = 3'd2,
        CFG_COORD_SHIFT = 3'd3,
        CFG_ORIGIN_X    = 3'd4,
        CFG_ORIGIN_Y    = 3'd5
    } cfg_idx_t;

    // Control that travels with a queue entry from the front to the back.
    typedef struct packed {
        logic  valid;
        op_e_t op;
    } cmd_ctl_t;

    // Tile offset (tile << (32 - zoom)) mod 2^32; zero zoom disables it,
    // and zooms of 32 and above use no shift at all.
    function automatic logic [31:0] tile_offset(input logic [5:0] zoom,
                                                input logic [31:0] tile);
        logic [5:0] sh;
        sh = (zoom >= 6'd32) ? 6'd0 : 6'(6'd32 - zoom);
        if (zoom == 6'd0) begin
            return 32'd0;
        end
        return tile << sh;
    endfunction

endpackage

// File: sv/pdd_front.sv
// Front end: accepts commands, scales deltas, and queues them for the back end.
module pdd_front #(
    parameter int COORD_WIDTH = pdd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic signed [32:0]            s_delta_x,
    input  logic signed [32:0]            s_delta_y,
    input  logic [5:0]                    zoom,
    input  logic [31:0]                   tile_x,
    input  logic [31:0]                   tile_y,
    input  logic [4:0]                    coord_shift,
    output pdd_pkg::cmd_ctl_t             q_ctl,
    output logic signed [COORD_WIDTH-1:0] q_dx,
    output logic signed [COORD_WIDTH-1:0] q_dx_rel,
    output logic signed [COORD_WIDTH-1:0] q_dy,
    output logic signed [COORD_WIDTH-1:0] q_dy_rel,
    input  logic                          q_pop
);
    import pdd_pkg::*;

    localparam int Depth = 2;

    logic signed [COORD_WIDTH-1:0] dx_ext, dy_ext;
    logic signed [COORD_WIDTH-1:0] dx_sh, dy_sh, dx_rel, dy_rel;
    logic [31:0] off_x, off_y;
    logic        push;

    op_e_t                         op_mem  [Depth];
    logic signed [COORD_WIDTH-1:0] dx_mem  [Depth];
    logic signed [COORD_WIDTH-1:0] dxr_mem [Depth];
    logic signed [COORD_WIDTH-1:0] dy_mem  [Depth];
    logic signed [COORD_WIDTH-1:0] dyr_mem [Depth];

    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    // Scale the deltas and fold the tile offset into a relative delta.
    always_comb begin
        dx_ext = COORD_WIDTH'(s_delta_x);
        dy_ext = COORD_WIDTH'(s_delta_y);
        dx_sh  = dx_ext << coord_shift;
        dy_sh  = dy_ext << coord_shift;
        off_x  = tile_offset(zoom, tile_x);
        off_y  = tile_offset(zoom, tile_y);
        dx_rel = dx_sh - COORD_WIDTH'(off_x);
        dy_rel = dy_sh - COORD_WIDTH'(off_y);
    end

    assign s_ready = (count_reg != 2'(Depth));
    assign push    = s_valid && s_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            op_mem[wr_ptr_reg]  <= op_e_t'(s_req_type);
            dx_mem[wr_ptr_reg]  <= dx_sh;
            dxr_mem[wr_ptr_reg] <= dx_rel;
            dy_mem[wr_ptr_reg]  <= dy_sh;
            dyr_mem[wr_ptr_reg] <= dy_rel;
        end
    end

    // Queue occupancy.
    always_comb begin
        count_next = count_reg;
        case ({push, q_pop})
            2'b10:   count_next = 2'(count_reg + 2'd1);
            2'b01:   count_next = 2'(count_reg - 2'd1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Head of the queue as seen by the back end.
    assign q_ctl.valid = (count_reg != 2'd0);
    assign q_ctl.op    = op_mem[rd_ptr_reg];
    assign q_dx        = dx_mem[rd_ptr_reg];
    assign q_dx_rel    = dxr_mem[rd_ptr_reg];
    assign q_dy        = dy_mem[rd_ptr_reg];
    assign q_dy_rel    = dyr_mem[rd_ptr_reg];

    // Occupancy never exceeds the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(Depth))
        else $error("queue occupancy above depth");

    // The back end only pops an entry that exists.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    // An accepted transaction leaves the queue non-empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> count_reg != 2'd0)
        else $error("accepted transaction lost");

endmodule

// File: sv/pdd_back.sv
// Back end: accumulates positions, tracks the bounding box and holds the result.
module pdd_back #(
    parameter int COORD_WIDTH = pdd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pdd_pkg::cmd_ctl_t             q_ctl,
    input  logic signed [COORD_WIDTH-1:0] q_dx,
    input  logic signed [COORD_WIDTH-1:0] q_dx_rel,
    input  logic signed [COORD_WIDTH-1:0] q_dy,
    input  logic signed [COORD_WIDTH-1:0] q_dy_rel,
    output logic                          q_pop,
    input  logic [31:0]                   origin_x,
    input  logic [31:0]                   origin_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_out_kind,
    output logic [1:0]                    m_out_op,
    output logic signed [63:0]            m_pos_x,
    output logic signed [63:0]            m_pos_y,
    output logic signed [63:0]            m_box_min_x,
    output logic signed [63:0]            m_box_min_y,
    output logic signed [63:0]            m_box_max_x,
    output logic signed [63:0]            m_box_max_y,
    output logic                          m_is_last
);
    import pdd_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] MaxCoord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MinCoord = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] world_x_reg, world_y_reg, world_x_next, world_y_next;
    logic signed [COORD_WIDTH-1:0] least_x_reg, least_y_reg, least_x_next, least_y_next;
    logic signed [COORD_WIDTH-1:0] most_x_reg, most_y_reg, most_x_next, most_y_next;
    logic signed [COORD_WIDTH-1:0] px, py;
    logic                          is_point, is_end;

    logic                          m_valid_reg;
    logic                          kind_reg, last_reg;
    logic [1:0]                    op_reg;
    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg;
    logic signed [COORD_WIDTH-1:0] bmin_x_reg, bmin_y_reg, bmax_x_reg, bmax_y_reg;

    // Take the queue head whenever the output register is free or draining.
    assign q_pop    = q_ctl.valid && (!m_valid_reg || m_ready);
    assign is_point = (q_ctl.op == OP_MOVE) || (q_ctl.op == OP_LINE);
    assign is_end   = (q_ctl.op == OP_END);

    // Position update and bounding box compare.
    always_comb begin
        px           = world_x_reg + q_dx_rel;
        py           = world_y_reg + q_dy_rel;
        world_x_next = world_x_reg;
        world_y_next = world_y_reg;
        least_x_next = least_x_reg;
        least_y_next = least_y_reg;
        most_x_next  = most_x_reg;
        most_y_next  = most_y_reg;
        if (is_end) begin
            world_x_next = COORD_WIDTH'(origin_x);
            world_y_next = COORD_WIDTH'(origin_y);
            least_x_next = MaxCoord;
            least_y_next = MaxCoord;
            most_x_next  = MinCoord;
            most_y_next  = MinCoord;
        end else if (is_point) begin
            world_x_next = world_x_reg + q_dx;
            world_y_next = world_y_reg + q_dy;
            if (px < least_x_reg) least_x_next = px;
            if (py < least_y_reg) least_y_next = py;
            if (px > most_x_reg)  most_x_next  = px;
            if (py > most_y_reg)  most_y_next  = py;
        end
    end

    // Accumulator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_x_reg <= '0;
            world_y_reg <= '0;
            least_x_reg <= MaxCoord;
            least_y_reg <= MaxCoord;
            most_x_reg  <= MinCoord;
            most_y_reg  <= MinCoord;
        end else if (q_pop) begin
            world_x_reg <= world_x_next;
            world_y_reg <= world_y_next;
            least_x_reg <= least_x_next;
            least_y_reg <= least_y_next;
            most_x_reg  <= most_x_next;
            most_y_reg  <= most_y_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload; a report carries the end code as its op.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= is_end;
            last_reg   <= is_end;
            op_reg     <= is_end ? OP_END : q_ctl.op;
            pos_x_reg  <= is_point ? px : '0;
            pos_y_reg  <= is_point ? py : '0;
            bmin_x_reg <= is_end ? least_x_reg : '0;
            bmin_y_reg <= is_end ? least_y_reg : '0;
            bmax_x_reg <= is_end ? most_x_reg : '0;
            bmax_y_reg <= is_end ? most_y_reg : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = kind_reg;
    assign m_is_last   = last_reg;
    assign m_out_op    = op_reg;
    assign m_pos_x     = OUT_WIDTH'(pos_x_reg);
    assign m_pos_y     = OUT_WIDTH'(pos_y_reg);
    assign m_box_min_x = OUT_WIDTH'(bmin_x_reg);
    assign m_box_min_y = OUT_WIDTH'(bmin_y_reg);
    assign m_box_max_x = OUT_WIDTH'(bmax_x_reg);
    assign m_box_max_y = OUT_WIDTH'(bmax_y_reg);

    // A stalled result is never overwritten by a new pop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !q_pop)
        else $error("result overwritten while stalled");

    // An end command leaves an empty box behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && is_end |=> least_x_reg == MaxCoord && most_y_reg == MinCoord)
        else $error("box not cleared after end");

    // After a point the box is well ordered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && is_point |=> least_x_reg <= most_x_reg && least_y_reg <= most_y_reg)
        else $error("bounding box out of order");

endmodule

// File: sv/path_delta_decode_bbox.sv
// Top level of the path delta decoder: configuration registers and the two halves.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_req_type, s_delta_x, s_delta_y
//  m_       out        m_valid / m_ready    m_out_kind, m_out_op, m_pos_*, m_box_*, m_is_last
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One command per clock cycle is sustained while m_ready is high; m_valid rises once its
// transaction has passed through the queue and the output register.
// The rate is set by the back end, which accumulates and compares combinationally.
// While m_ready is low, the two-entry queue and the output register take up to three
// transactions; s_ready drops once the queue holds two entries.
// aresetn is synchronous and active low; it clears configuration, queue and box state.
module path_delta_decode_bbox #(
    parameter int COORD_WIDTH = pdd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_req_type,
    input  logic signed [32:0]                   s_delta_x,
    input  logic signed [32:0]                   s_delta_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_out_kind,
    output logic [1:0]                           m_out_op,
    output logic signed [63:0]                   m_pos_x,
    output logic signed [63:0]                   m_pos_y,
    output logic signed [63:0]                   m_box_min_x,
    output logic signed [63:0]                   m_box_min_y,
    output logic signed [63:0]                   m_box_max_x,
    output logic signed [63:0]                   m_box_max_y,
    output logic                                 m_is_last,
    input  logic                                 cfg_wr_en,
    input  logic [pdd_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [pdd_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
    import pdd_pkg::*;

    logic [5:0]  zoom_reg;
    logic [31:0] tile_x_reg, tile_y_reg, origin_x_reg, origin_y_reg;
    logic [4:0]  coord_shift_reg;

    cmd_ctl_t                      q_ctl;
    logic signed [COORD_WIDTH-1:0] q_dx, q_dx_rel, q_dy, q_dy_rel;
    logic                          q_pop;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg        <= '0;
            tile_x_reg      <= '0;
            tile_y_reg      <= '0;
            coord_shift_reg <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ZOOM:        zoom_reg        <= cfg_wdata[5:0];
                CFG_TILE_X:      tile_x_reg      <= cfg_wdata;
                CFG_TILE_Y:      tile_y_reg      <= cfg_wdata;
                CFG_COORD_SHIFT: coord_shift_reg <= cfg_wdata[4:0];
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front end: accept, scale and queue.
    pdd_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_delta_x   (s_delta_x),
        .s_delta_y   (s_delta_y),
        .zoom        (zoom_reg),
        .tile_x      (tile_x_reg),
        .tile_y      (tile_y_reg),
        .coord_shift (coord_shift_reg),
        .q_ctl       (q_ctl),
        .q_dx        (q_dx),
        .q_dx_rel    (q_dx_rel),
        .q_dy        (q_dy),
        .q_dy_rel    (q_dy_rel),
        .q_pop       (q_pop)
    );

    // Back end: accumulate, track the box and drive the result channel.
    pdd_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_ctl       (q_ctl),
        .q_dx        (q_dx),
        .q_dx_rel    (q_dx_rel),
        .q_dy        (q_dy),
        .q_dy_rel    (q_dy_rel),
        .q_pop       (q_pop),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_op    (m_out_op),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_box_min_x (m_box_min_x),
        .m_box_min_y (m_box_min_y),
        .m_box_max_x (m_box_max_x),
        .m_box_max_y (m_box_max_y),
        .m_is_last   (m_is_last)
    );

endmodule
